// ----- sv/srws_pkg.sv -----
`timescale 1ns / 1ps

package srws_pkg;

    localparam int ADDR_BITS_DEF = 8;
    localparam int DATA_BITS_DEF = 16;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd500;

    typedef struct packed {
        logic        command;
        logic [7:0]  reg_address;
        logic [15:0] reg_value;
    } t_in_item;

    typedef struct packed {
        logic chip_select_n;
        logic serial_clock;
        logic serial_data_out;
        logic busy_res;
        logic rejected;
    } t_out_item;

endpackage

// ----- sv/srws_engine.sv -----
`timescale 1ns / 1ps

module srws_engine
    import srws_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [15:0] i_phase_ticks,
    input  t_in_item    i_item,
    output t_out_item   o_result
);

    localparam int FRAME_BITS = ADDR_BITS + DATA_BITS;
    localparam int BL_W       = $clog2(FRAME_BITS + 1);
    localparam int IDX_W      = $clog2(FRAME_BITS);

    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;

    logic [FRAME_BITS-1:0] r_frame_shift, n_frame_shift;
    logic [BL_W-1:0]       r_bits_left, n_bits_left;
    logic [1:0]            r_phase, n_phase;
    logic [15:0]           r_phase_timer, n_phase_timer;
    logic                  r_active, n_active;
    logic                  r_in_guard, n_in_guard;

    logic [15:0]           limit;
    logic [31:0]           addr_ext;
    logic [31:0]           data_ext;
    logic [BL_W-1:0]       bits_m1;
    logic [IDX_W-1:0]      bit_idx;
    logic [16:0]           timer_sum;

    assign limit    = (i_phase_ticks == '0) ? 16'd1 : i_phase_ticks;
    assign addr_ext = 32'(i_item.reg_address);
    assign data_ext = 32'(i_item.reg_value);

    always_comb begin
        n_frame_shift = r_frame_shift;
        n_bits_left   = r_bits_left;
        n_phase       = r_phase;
        n_phase_timer = r_phase_timer;
        n_active      = r_active;
        n_in_guard    = r_in_guard;
        o_result      = '0;

        // take or drop the request first
        if (i_item.command) begin
            if (r_active || r_in_guard) begin
                o_result.rejected = 1'b1;
            end else begin
                n_frame_shift = {addr_ext[ADDR_BITS-1:0], data_ext[DATA_BITS-1:0]};
                n_bits_left   = BL_W'(FRAME_BITS);
                n_phase       = PH_SETUP;
                n_phase_timer = '0;
                n_active      = 1'b1;
            end
        end

        bits_m1 = n_bits_left - 1'b1;
        bit_idx = bits_m1[IDX_W-1:0];

        o_result.chip_select_n   = ~n_active;
        o_result.serial_clock    = n_active && (n_phase == PH_HIGH);
        o_result.serial_data_out = n_active ? n_frame_shift[bit_idx] : n_frame_shift[0];
        o_result.busy_res        = n_active || n_in_guard;

        // advance the phase timer
        timer_sum = {1'b0, n_phase_timer} + 17'd1;
        if (n_active || n_in_guard) begin
            if (timer_sum >= {1'b0, limit}) begin
                n_phase_timer = '0;
                if (n_active) begin
                    if (n_phase < PH_LOW) begin
                        n_phase = n_phase + 2'd1;
                    end else begin
                        n_phase = PH_SETUP;
                        if (n_bits_left != '0) begin
                            n_bits_left = n_bits_left - 1'b1;
                        end
                        if (n_bits_left == '0) begin
                            n_active   = 1'b0;
                            n_in_guard = 1'b1;
                        end
                    end
                end else begin
                    n_in_guard = 1'b0;
                end
            end else begin
                n_phase_timer = timer_sum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_shift <= '0;
            r_bits_left   <= '0;
            r_phase       <= PH_SETUP;
            r_phase_timer <= '0;
            r_active      <= 1'b0;
            r_in_guard    <= 1'b0;
        end else if (i_step) begin
            r_frame_shift <= n_frame_shift;
            r_bits_left   <= n_bits_left;
            r_phase       <= n_phase;
            r_phase_timer <= n_phase_timer;
            r_active      <= n_active;
            r_in_guard    <= n_in_guard;
        end
    end

endmodule

// ----- sv/spi_register_write_serializer.sv -----
`timescale 1ns / 1ps
// A tick's result is formed combinationally and captured in the output
// register at the edge that accepts the transfer. One tick per cycle while
// the sink does not stall a waiting result; the frame state and phase timer
// update in one pass, and a single output register parts the two channels.
// Reset (i_rst_n low, synchronous): idle, chip select high, phase_ticks 500.

module spi_register_write_serializer
    import srws_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_PHASE_TICKS = 1'b0;

    logic [15:0] r_phase_ticks;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item;
    t_out_item   result;
    logic        step;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PHASE_TICKS) ? 32'(r_phase_ticks) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_PHASE_TICKS) begin
            r_phase_ticks <= pwdata[15:0];
        end
    end

    // hold off input only while a result waits and the sink stalls
    assign o_in_stall = r_out_valid && i_out_stall;
    assign step       = i_in_valid && !o_in_stall;

    srws_engine #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_phase_ticks (r_phase_ticks),
        .i_item        (i_in_item),
        .o_result      (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- sv/srws_checker.sv -----
`timescale 1ns / 1ps

module srws_checker
    import srws_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_item    i_in_item,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // input is held off only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    // a request either starts a frame or is dropped; busy either way
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.command |=>
            o_out_valid && o_out_item.busy_res)
        else $error("request transfer did not report busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.rejected |-> o_out_item.busy_res)
        else $error("request dropped while idle");

    a_sck_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.serial_clock || !o_out_item.chip_select_n) |->
            o_out_item.busy_res && !o_out_item.chip_select_n)
        else $error("serial clock or chip select outside a frame");

endmodule

bind spi_register_write_serializer srws_checker u_srws_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import srws_pkg::*;

    localparam int FRAME_BITS = ADDR_BITS_DEF + DATA_BITS_DEF;
    localparam logic [2:0] REG_PHASE_TICKS = 3'd0;
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 200;

    typedef enum logic [1:0] {PH_SETUP, PH_HIGH, PH_LOW} t_bit_phase;
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_ALTERNATE, STALL_BURSTY} t_stall_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    in_item = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the transmitter state
    logic [15:0]           cfg_ticks = PHASE_TICKS_RST;
    logic [FRAME_BITS-1:0] fr_shift = '0;
    int                    bits_rem = 0;
    t_bit_phase            ph = PH_SETUP;
    int                    ph_timer = 0;
    logic                  fr_active = 1'b0;
    logic                  fr_guard = 1'b0;

    t_out_item pin_levels_q[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        sender_gaps = 1'b0;
    int        burst_left = 0;
    bit        hold_req = 1'b0;

    spi_register_write_serializer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // One tick: take or reject the request, form the pins, then advance the timer.
    function automatic t_out_item next_pin_levels(input t_in_item item);
        t_out_item pins;
        int lim;
        lim = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
        pins.rejected = 1'b0;
        if (item.command == CMD_WRITE) begin
            if (fr_active || fr_guard) begin
                pins.rejected = 1'b1;
            end else begin
                fr_shift = {item.reg_address, item.reg_value};
                bits_rem = FRAME_BITS;
                ph = PH_SETUP;
                ph_timer = 0;
                fr_active = 1'b1;
            end
        end
        pins.chip_select_n = !fr_active;
        pins.serial_clock = fr_active && (ph == PH_HIGH);
        if (fr_active && bits_rem > 0)
            pins.serial_data_out = fr_shift[bits_rem-1];
        else
            pins.serial_data_out = fr_shift[0];
        pins.busy_res = fr_active || fr_guard;
        if (fr_active || fr_guard) begin
            ph_timer++;
            if (ph_timer >= lim) begin
                ph_timer = 0;
                if (fr_active) begin
                    case (ph)
                        PH_SETUP: ph = PH_HIGH;
                        PH_HIGH: ph = PH_LOW;
                        default: begin
                            ph = PH_SETUP;
                            if (bits_rem > 0)
                                bits_rem--;
                            if (bits_rem == 0) begin
                                fr_active = 1'b0;
                                fr_guard = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    fr_guard = 1'b0;
                end
            end
        end
        return pins;
    endfunction

    function automatic void report_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s expected %b actual %b", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : check_pins
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pin_levels_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual %p", $time, o_out_item);
                errors++;
            end else begin
                want = pin_levels_q.pop_front();
                report_field("chip_select_n", want.chip_select_n, o_out_item.chip_select_n);
                report_field("serial_clock", want.serial_clock, o_out_item.serial_clock);
                report_field("serial_data_out", want.serial_data_out,
                             o_out_item.serial_data_out);
                report_field("busy_res", want.busy_res, o_out_item.busy_res);
                report_field("rejected", want.rejected, o_out_item.rejected);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : receiver
        t_stall_mode mode;
        int left;
        int pat;
        mode = STALL_NONE;
        left = 0;
        pat = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    left = $urandom_range(20, 120);
                end
                left--;
                pat++;
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                    STALL_ALTERNATE: out_stall <= (pat % 2 == 0);
                    default: out_stall <= (pat % 8 < 5);
                endcase
            end
        end
    end

    task automatic send_tick(input logic cmd, input logic [7:0] addr, input logic [15:0] data);
        t_in_item item;
        item = '{command: cmd, reg_address: addr, reg_value: data};
        if (sender_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        pin_levels_q.push_back(next_pin_levels(item));
    endtask

    task automatic send_random_tick(input int req_pct);
        send_tick(($urandom_range(0, 99) < req_pct) ? CMD_WRITE : CMD_TICK,
                  8'($urandom), 16'($urandom));
    endtask

    // Plain ticks until the frame and its guard are over; poke the guard with requests.
    task automatic run_until_idle();
        while (fr_active || fr_guard)
            send_tick((fr_guard && $urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_TICK,
                      8'($urandom), 16'($urandom));
    endtask

    task automatic drain_pins();
        in_valid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge clk);
    endtask

    // Write phase_ticks with nothing in flight, then read it back.
    task automatic set_phase_ticks(input logic [15:0] val);
        drain_pins();
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_PHASE_TICKS;
        pwdata <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        cfg_ticks = val;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== {16'h0, val}) begin
            $display("%0t: phase_ticks read expected %h actual %h", $time, {16'h0, val},
                     prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [15:0] data);
        send_tick(CMD_WRITE, addr, data);
        run_until_idle();
    endtask

    task automatic test_default_length();
        sender_gaps = 1'b0;
        repeat (5) send_random_tick(0);
        send_tick(CMD_WRITE, 8'hFF, 16'hFFFF);
        repeat (12) send_random_tick(0);
        send_tick(CMD_WRITE, 8'h00, 16'h0000);
        repeat (12) send_random_tick(0);
        // shorten mid-phase: the running phase ends on the next tick
        set_phase_ticks(16'd0);
        run_until_idle();
    endtask

    task automatic test_field_extremes();
        set_phase_ticks(16'd1);
        sender_gaps = 1'b1;
        send_frame(8'h00, 16'h0000);
        send_frame(8'hFF, 16'hFFFF);
        send_frame(8'h80, 16'h0001);
        send_frame(8'h01, 16'h8000);
        send_frame(8'h5A, 16'hA5C3);
    endtask

    task automatic test_length_extremes();
        set_phase_ticks(16'hFFFF);
        send_tick(CMD_WRITE, 8'($urandom), 16'($urandom));
        repeat (40) send_random_tick(5);
        set_phase_ticks(16'd2);
        run_until_idle();
        set_phase_ticks(16'd0);
        send_frame(8'($urandom), 16'($urandom));
    endtask

    task automatic test_output_hold_off();
        set_phase_ticks(16'd1);
        sender_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (200) send_random_tick(10);
    endtask

    task automatic test_pause_for_results();
        sender_gaps = 1'b1;
        repeat (4) begin
            repeat ($urandom_range(10, 30)) send_random_tick(10);
            drain_pins();
        end
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        logic [15:0] len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 16'd0;
                1, 2, 3, 4, 5: len = 16'd1;
                6, 7: len = 16'd2;
                8: len = 16'd3;
                default: len = 16'($urandom_range(4, 10));
            endcase
            // lands mid-frame more often than not
            set_phase_ticks(len);
            sender_gaps = ($urandom_range(0, 3) != 0);
            n = $urandom_range(40, 120);
            repeat (n) send_random_tick((fr_active || fr_guard) ? 3 : 50);
            sent += n;
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_default_length();
        test_field_extremes();
        test_length_extremes();
        test_output_hold_off();
        test_pause_for_results();
        test_random_traffic();
        drain_pins();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
